// ----- rtl/core/esw_pkg.sv -----
package esw_pkg;

    // window sizing
    localparam int MAX_WINDOW = 16;
    localparam int PAIRS_W    = $clog2(MAX_WINDOW + 1);

    // field widths
    localparam int ANGLE_W     = 14;
    localparam int INTERVAL_W  = 16;
    localparam int WINLEN_W    = 5;
    localparam int SPEED_W     = 32;
    localparam int COUNT_OUT_W = 19;
    localparam int TIME_OUT_W  = 20;

    // accumulator widths
    localparam int DIFF_W = ANGLE_W + 2;
    localparam int CNT_W  = ANGLE_W + 2 + $clog2(MAX_WINDOW);
    localparam int TIME_W = INTERVAL_W + $clog2(MAX_WINDOW);

    localparam int ANGLE_MOD = 1 << ANGLE_W;

    // speed scaling: counts per microsecond to Q16.16 turns per second
    localparam int                 SCALE_W   = 22;
    localparam logic [SCALE_W-1:0] Q16_SCALE = SCALE_W'(4000000);
    localparam int                 MAG_W     = CNT_W - 1;
    localparam int                 NUM_W     = MAG_W + SCALE_W;
    localparam int                 STEP_W    = $clog2(NUM_W);

    // request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_INTERVAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WRAP_THRESH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_LENGTH = CFG_IDX_W'(2);

    localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL  = INTERVAL_W'(2500);
    localparam logic [ANGLE_W-1:0]    RST_WRAP_THRESH   = ANGLE_W'(10467);
    localparam logic [WINLEN_W-1:0]   RST_WINDOW_LENGTH = WINLEN_W'(8);

    typedef struct packed {
        logic [INTERVAL_W-1:0] max_interval_us;
        logic [ANGLE_W-1:0]    wrap_threshold;
        logic [WINLEN_W-1:0]   window_length;
    } t_cfg;

    typedef struct packed {
        logic signed [CNT_W-1:0] count_sum;
        logic [TIME_W-1:0]       time_sum;
    } t_window;

endpackage

// ----- rtl/core/esw_front.sv -----
module esw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esw_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [esw_pkg::ANGLE_W-1:0]   i_angle_first,
    input  logic [esw_pkg::ANGLE_W-1:0]   i_angle_second,
    input  logic                          i_first_failed,
    input  logic                          i_second_failed,
    input  logic [esw_pkg::INTERVAL_W-1:0] i_interval_us,
    output logic                          o_push,
    output esw_pkg::t_window              o_window,
    input  logic                          i_full
);
    import esw_pkg::*;

    logic signed [CNT_W-1:0] r_count;
    logic [TIME_W-1:0]       r_time;
    logic [PAIRS_W-1:0]      r_pairs;

    logic                     accept;
    logic                     reject;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] thresh;
    logic signed [DIFF_W-1:0] diff_fix;
    logic signed [CNT_W-1:0]  n_count;
    logic [TIME_W-1:0]        n_time;
    logic [PAIRS_W-1:0]       n_pairs;
    logic [PAIRS_W-1:0]       eff_window;
    logic                     done;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign reject  = i_first_failed || i_second_failed
                     || (i_interval_us > i_cfg.max_interval_us);

    // zero crossing correction
    always_comb begin
        diff   = $signed({2'b00, i_angle_first}) - $signed({2'b00, i_angle_second});
        thresh = $signed({2'b00, i_cfg.wrap_threshold});
        if (diff > thresh) begin
            diff_fix = diff - $signed(DIFF_W'(ANGLE_MOD));
        end else if (diff < -thresh) begin
            diff_fix = diff + $signed(DIFF_W'(ANGLE_MOD));
        end else begin
            diff_fix = diff;
        end
    end

    always_comb begin
        if (i_cfg.window_length == '0) begin
            eff_window = PAIRS_W'(1);
        end else if (int'(i_cfg.window_length) > MAX_WINDOW) begin
            eff_window = PAIRS_W'(MAX_WINDOW);
        end else begin
            eff_window = PAIRS_W'(i_cfg.window_length);
        end
    end

    assign n_count = r_count + CNT_W'(diff_fix);
    assign n_time  = r_time + TIME_W'(i_interval_us);
    assign n_pairs = r_pairs + PAIRS_W'(1);
    assign done    = (n_pairs >= eff_window);

    assign o_push             = accept && !reject && done;
    assign o_window.count_sum = n_count;
    assign o_window.time_sum  = n_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
            r_pairs <= '0;
        end else if (accept && !reject) begin
            if (done) begin
                r_count <= '0;
                r_time  <= '0;
                r_pairs <= '0;
            end else begin
                r_count <= n_count;
                r_time  <= n_time;
                r_pairs <= n_pairs;
            end
        end
    end

endmodule

// ----- rtl/core/esw_queue.sv -----
module esw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  esw_pkg::t_window i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output esw_pkg::t_window o_data
);
    import esw_pkg::*;

    t_window             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (int'(r_wptr) == QUEUE_DEPTH - 1) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (int'(r_rptr) == QUEUE_DEPTH - 1) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/esw_back.sv -----
module esw_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  esw_pkg::t_window                    i_window,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [esw_pkg::SPEED_W-1:0]   o_speed_q16,
    output logic signed [esw_pkg::COUNT_OUT_W-1:0] o_count_total,
    output logic [esw_pkg::TIME_OUT_W-1:0]       o_time_total_us,
    output logic                                o_saturated
);
    import esw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic [TIME_W-1:0]       r_div;
    logic [TIME_W-1:0]       r_rem;
    logic [NUM_W-1:0]        r_num;
    logic [STEP_W-1:0]       r_step;
    logic signed [CNT_W-1:0] r_count;
    logic                    r_out_valid;

    logic [CNT_W-1:0]   abs_count;
    logic [TIME_W:0]    rem_sh;
    logic [TIME_W:0]    rem_sub;
    logic               ge;
    logic               pos_over;
    logic               neg_over;
    logic               sat;
    logic [SPEED_W-1:0] speed;
    logic               load_out;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_out_valid;

    // output register takes a new result when empty or being drained
    assign load_out = (r_state == S_FIN) && (!r_out_valid || i_ready);

    assign abs_count = i_window.count_sum[CNT_W-1] ? (~i_window.count_sum + CNT_W'(1))
                                                   : i_window.count_sum;

    // one quotient bit per cycle
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    // clip magnitude to the signed range
    assign pos_over = |r_num[NUM_W-1:SPEED_W-1];
    assign neg_over = (|r_num[NUM_W-1:SPEED_W])
                      || (r_num[SPEED_W-1] && (|r_num[SPEED_W-2:0]));

    always_comb begin
        if (r_div == '0) begin
            sat = (r_mag != '0);
            if (r_mag == '0) begin
                speed = '0;
            end else if (r_neg) begin
                speed = {1'b1, {(SPEED_W-1){1'b0}}};
            end else begin
                speed = {1'b0, {(SPEED_W-1){1'b1}}};
            end
        end else if (r_neg) begin
            sat   = neg_over;
            speed = neg_over ? {1'b1, {(SPEED_W-1){1'b0}}} : (~r_num[SPEED_W-1:0] + SPEED_W'(1));
        end else begin
            sat   = pos_over;
            speed = pos_over ? {1'b0, {(SPEED_W-1){1'b1}}} : r_num[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_neg   <= i_window.count_sum[CNT_W-1];
                        r_mag   <= abs_count[MAG_W-1:0];
                        r_div   <= i_window.time_sum;
                        r_count <= i_window.count_sum;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_num   <= r_mag * Q16_SCALE;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= (r_div == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                    r_num  <= {r_num[NUM_W-2:0], ge};
                    r_step <= r_step + STEP_W'(1);
                    if (int'(r_step) == NUM_W - 1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load_out) begin
                        o_speed_q16     <= $signed(speed);
                        o_count_total   <= COUNT_OUT_W'(r_count);
                        o_time_total_us <= TIME_OUT_W'(r_div);
                        o_saturated     <= sat;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/encoder_speed_window_top.sv -----
// windowed angular speed from pairs of 14-bit encoder readings. the front end
// takes one reading pair per clock while the window queue has room: a pair
// with an error flag or an interval above max_interval_us is dropped, else
// its wrap-corrected difference (first minus second) and interval are added
// to the window sums in that same cycle. once window_length good pairs are
// in (0 acts as 1, values above 16 act as 16) the window sums are queued
// (two deep) and cleared. the back end turns each queued window into
// count_sum * 4000000 / time_sum, signed q16.16 turns per second, truncated
// toward zero and clipped to 32 bits with the saturated flag set; a zero time
// sum gives full scale by sign, or zero. once a window closes, the back end
// takes it off the queue, multiplies it, runs a 41-step restoring divider
// that retires one quotient bit per clock and loads the output register; a
// zero time sum skips the divider. a result left waiting holds the back end,
// and the front end stalls once two windows are queued. configuration is to
// be written by the user only while the block is idle; the block itself
// does not enforce this.
module encoder_speed_window_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [esw_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [esw_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // reading pair request
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [esw_pkg::ANGLE_W-1:0]            i_angle_first,
    input  logic [esw_pkg::ANGLE_W-1:0]            i_angle_second,
    input  logic                                  i_first_failed,
    input  logic                                  i_second_failed,
    input  logic [esw_pkg::INTERVAL_W-1:0]         i_interval_us,
    // speed result request
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [esw_pkg::SPEED_W-1:0]     o_speed_q16,
    output logic signed [esw_pkg::COUNT_OUT_W-1:0] o_count_total,
    output logic [esw_pkg::TIME_OUT_W-1:0]         o_time_total_us,
    output logic                                  o_saturated
);
    import esw_pkg::*;

    t_cfg    r_cfg;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_window q_in;
    t_window q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_interval_us <= RST_MAX_INTERVAL;
            r_cfg.wrap_threshold  <= RST_WRAP_THRESH;
            r_cfg.window_length   <= RST_WINDOW_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_MAX_INTERVAL:  r_cfg.max_interval_us <= i_cfg_data[INTERVAL_W-1:0];
                CFG_IDX_WRAP_THRESH:   r_cfg.wrap_threshold  <= i_cfg_data[ANGLE_W-1:0];
                CFG_IDX_WINDOW_LENGTH: r_cfg.window_length   <= i_cfg_data[WINLEN_W-1:0];
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    // classify and accumulate pairs
    esw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_angle_first   (i_angle_first),
        .i_angle_second  (i_angle_second),
        .i_first_failed  (i_first_failed),
        .i_second_failed (i_second_failed),
        .i_interval_us   (i_interval_us),
        .o_push          (q_push),
        .o_window        (q_in),
        .i_full          (q_full)
    );

    // closed windows waiting for the divider
    esw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // scale, divide, clip and hold the result
    esw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_window        (q_out),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_speed_q16     (o_speed_q16),
        .o_count_total   (o_count_total),
        .o_time_total_us (o_time_total_us),
        .o_saturated     (o_saturated)
    );

endmodule

// ----- verif/esw_speed_checker.sv -----
module esw_speed_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [esw_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [esw_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                  i_pair_valid,
    input  logic                                  i_pair_ready,
    input  logic [esw_pkg::ANGLE_W-1:0]            i_angle_first,
    input  logic [esw_pkg::ANGLE_W-1:0]            i_angle_second,
    input  logic                                  i_first_failed,
    input  logic                                  i_second_failed,
    input  logic [esw_pkg::INTERVAL_W-1:0]         i_interval_us,
    input  logic                                  i_res_valid,
    input  logic                                  i_res_ready,
    input  logic signed [esw_pkg::SPEED_W-1:0]     i_speed_q16,
    input  logic signed [esw_pkg::COUNT_OUT_W-1:0] i_count_total,
    input  logic [esw_pkg::TIME_OUT_W-1:0]         i_time_total_us,
    input  logic                                  i_saturated,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);

    import esw_pkg::*;

    localparam longint SPEED_SCALE = 64'sd4000000;
    localparam longint SPEED_MAX   = 64'sd2147483647;
    localparam longint SPEED_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic signed [SPEED_W-1:0]     speed;
        logic signed [COUNT_OUT_W-1:0] count;
        logic [TIME_OUT_W-1:0]         window_us;
        logic                          sat;
    } speed_rec_t;

    // register copies
    logic [INTERVAL_W-1:0] lim_interval;
    logic [ANGLE_W-1:0]    wrap_span;
    logic [WINLEN_W-1:0]   win_len;

    // window sums
    int win_count;
    int win_time;
    int win_pairs;

    speed_rec_t speed_q[$];

    // adds one reading pair to the window unless it is rejected, returns 1 when the window closes
    function automatic bit fold_pair(input logic [ANGLE_W-1:0] a1, input logic [ANGLE_W-1:0] a2,
                                     input logic f1, input logic f2,
                                     input logic [INTERVAL_W-1:0] dt, output speed_rec_t rec);
        int     diff;
        int     span;
        int     eff_len;
        longint quo;
        bit     clip;
        rec  = '0;
        clip = 1'b0;
        if (f1 || f2 || dt > lim_interval) return 1'b0;
        span = int'(wrap_span);
        diff = int'(a1) - int'(a2);
        if (diff > span) diff -= ANGLE_MOD;
        else if (diff < -span) diff += ANGLE_MOD;
        win_count += diff;
        win_time  += int'(dt);
        win_pairs += 1;
        eff_len = (win_len == 0) ? 1 : (int'(win_len) > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
        if (win_pairs < eff_len) return 1'b0;
        if (win_time == 0) begin
            if (win_count > 0) begin
                quo  = SPEED_MAX;
                clip = 1'b1;
            end else if (win_count < 0) begin
                quo  = SPEED_MIN;
                clip = 1'b1;
            end else begin
                quo = 0;
            end
        end else begin
            quo = (longint'(win_count) * SPEED_SCALE) / longint'(win_time);
            if (quo > SPEED_MAX) begin
                quo  = SPEED_MAX;
                clip = 1'b1;
            end else if (quo < SPEED_MIN) begin
                quo  = SPEED_MIN;
                clip = 1'b1;
            end
        end
        rec.speed     = quo[SPEED_W-1:0];
        rec.count     = win_count[COUNT_OUT_W-1:0];
        rec.window_us = win_time[TIME_OUT_W-1:0];
        rec.sat       = clip;
        win_count = 0;
        win_time  = 0;
        win_pairs = 0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        speed_rec_t want;
        speed_rec_t got;
        if (!i_rst_n) begin
            lim_interval = RST_MAX_INTERVAL;
            wrap_span    = RST_WRAP_THRESH;
            win_len      = RST_WINDOW_LENGTH;
            win_count    = 0;
            win_time     = 0;
            win_pairs    = 0;
            speed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_MAX_INTERVAL:  lim_interval = i_cfg_data[INTERVAL_W-1:0];
                    CFG_IDX_WRAP_THRESH:   wrap_span    = i_cfg_data[ANGLE_W-1:0];
                    CFG_IDX_WINDOW_LENGTH: win_len      = i_cfg_data[WINLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_pair_valid && i_pair_ready) begin
                if (fold_pair(i_angle_first, i_angle_second, i_first_failed, i_second_failed,
                              i_interval_us, want))
                    speed_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                got = '{i_speed_q16, i_count_total, i_time_total_us, i_saturated};
                if (speed_q.size() == 0) begin
                    $display("%0t: speed result with nothing expected: speed %0d count %0d time %0d",
                             $time, got.speed, got.count, got.window_us);
                    o_fail_count++;
                end else begin
                    want = speed_q.pop_front();
                    o_checked++;
                    if (got.speed !== want.speed) begin
                        $display("%0t: speed_q16 expected %0d actual %0d",
                                 $time, want.speed, got.speed);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count_total expected %0d actual %0d",
                                 $time, want.count, got.count);
                        o_fail_count++;
                    end
                    if (got.window_us !== want.window_us) begin
                        $display("%0t: time_total_us expected %0d actual %0d",
                                 $time, want.window_us, got.window_us);
                        o_fail_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.sat, got.sat);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = speed_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    import esw_pkg::*;

    // cycles to let the divider finish after the last expected speed
    localparam int DRAIN_CYCLES = 60;
    localparam int SEG_PAIRS    = 80;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data      = '0;
    logic                          i_valid         = 1'b0;
    logic                          o_ready;
    logic [ANGLE_W-1:0]            i_angle_first   = '0;
    logic [ANGLE_W-1:0]            i_angle_second  = '0;
    logic                          i_first_failed  = 1'b0;
    logic                          i_second_failed = 1'b0;
    logic [INTERVAL_W-1:0]         i_interval_us   = '0;
    logic                          o_valid;
    logic                          i_ready         = 1'b0;
    logic signed [SPEED_W-1:0]     o_speed_q16;
    logic signed [COUNT_OUT_W-1:0] o_count_total;
    logic [TIME_OUT_W-1:0]         o_time_total_us;
    logic                          o_saturated;

    int fail_count;
    int pending;
    int checked;

    // idle odds in percent for the request side and the result side
    int tx_idle_pct = 19;
    int rx_idle_pct = 66;

    // what was last written to max_interval_us, used to aim the intervals
    int cur_max_interval = 2500;
    int pairs_sent       = 0;
    int settings_used    = 0;

    encoder_speed_window_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_angle_first   (i_angle_first),
        .i_angle_second  (i_angle_second),
        .i_first_failed  (i_first_failed),
        .i_second_failed (i_second_failed),
        .i_interval_us   (i_interval_us),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_speed_q16     (o_speed_q16),
        .o_count_total   (o_count_total),
        .o_time_total_us (o_time_total_us),
        .o_saturated     (o_saturated)
    );

    // predicts every speed result and compares what comes out
    esw_speed_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pair_valid    (i_valid),
        .i_pair_ready    (o_ready),
        .i_angle_first   (i_angle_first),
        .i_angle_second  (i_angle_second),
        .i_first_failed  (i_first_failed),
        .i_second_failed (i_second_failed),
        .i_interval_us   (i_interval_us),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_speed_q16     (o_speed_q16),
        .i_count_total   (o_count_total),
        .i_time_total_us (o_time_total_us),
        .i_saturated     (o_saturated),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side stalls at random, odds set per phase
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one reading pair request; called at a falling edge, returns at one.
    // valid is left high so a following request can go out back to back
    task automatic send_pair(input logic [ANGLE_W-1:0] a1, input logic [ANGLE_W-1:0] a2,
                             input logic f1, input logic f2, input logic [INTERVAL_W-1:0] dt);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_angle_first   <= a1;
        i_angle_second  <= a2;
        i_first_failed  <= f1;
        i_second_failed <= f2;
        i_interval_us   <= dt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        pairs_sent++;
    endtask

    // drop valid and wait for the block to drain before touching registers
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_IDX_MAX_INTERVAL) cur_max_interval = value;
    endtask

    task automatic apply_setting(input int max_iv, input int wrap, input int win);
        settle();
        write_reg(CFG_IDX_MAX_INTERVAL, max_iv);
        write_reg(CFG_IDX_WRAP_THRESH, wrap);
        write_reg(CFG_IDX_WINDOW_LENGTH, win);
        settings_used++;
    endtask

    // mostly good pairs; some straddle the zero crossing, some carry an
    // error flag, some have an interval past the limit
    task automatic send_random_pair();
        logic [ANGLE_W-1:0]    a1;
        logic [ANGLE_W-1:0]    a2;
        logic [ANGLE_W-1:0]    swap;
        logic                  f1;
        logic                  f2;
        logic [INTERVAL_W-1:0] dt;
        int                    pick;
        a1 = ANGLE_W'($urandom_range(16383));
        a2 = ANGLE_W'($urandom_range(16383));
        if ($urandom_range(3) == 0) begin
            a1 = ANGLE_W'($urandom_range(300));
            a2 = ANGLE_W'(16383 - $urandom_range(300));
            if ($urandom_range(1) == 1) begin
                swap = a1;
                a1   = a2;
                a2   = swap;
            end
        end
        f1   = ($urandom_range(99) < 8);
        f2   = ($urandom_range(99) < 8);
        pick = $urandom_range(99);
        if (pick < 10)
            dt = INTERVAL_W'($urandom_range((cur_max_interval < 3) ? cur_max_interval : 3));
        else if (pick < 85 || cur_max_interval >= 65535)
            dt = INTERVAL_W'($urandom_range(cur_max_interval));
        else
            dt = INTERVAL_W'($urandom_range(65535, cur_max_interval + 1));
        send_pair(a1, a2, f1, f2, dt);
    endtask

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int k;
        int max_iv;
        int wrap;
        int win;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one pair per window so each case shows up on its own
        apply_setting(65535, 10467, 1);
        send_pair(14'd16383, 14'd0, 1'b0, 1'b0, 16'd65535);    // wraps down to -1
        send_pair(14'd0, 14'd16383, 1'b0, 1'b0, 16'd65535);    // wraps up to +1
        send_pair(14'd10467, 14'd0, 1'b0, 1'b0, 16'd1);        // at threshold, clips high
        send_pair(14'd0, 14'd10467, 1'b0, 1'b0, 16'd1);        // at threshold, clips low
        send_pair(14'd10468, 14'd0, 1'b0, 1'b0, 16'd40000);    // just past threshold
        send_pair(14'd123, 14'd456, 1'b1, 1'b0, 16'd100);      // first reading bad
        send_pair(14'd123, 14'd456, 1'b0, 1'b1, 16'd100);      // second reading bad
        send_pair(14'd16383, 14'd16383, 1'b1, 1'b1, 16'd0);    // both bad
        send_pair(14'd5, 14'd0, 1'b0, 1'b0, 16'd0);            // zero time, positive count
        send_pair(14'd0, 14'd5, 1'b0, 1'b0, 16'd0);            // zero time, negative count
        send_pair(14'd100, 14'd100, 1'b0, 1'b0, 16'd0);        // zero time, zero count

        // interval right at the limit and one past it
        settle();
        write_reg(CFG_IDX_MAX_INTERVAL, 1000);
        send_pair(14'd0, 14'd1, 1'b0, 1'b0, 16'd1000);
        send_pair(14'd1, 14'd0, 1'b0, 1'b0, 16'd1001);

        // window length zero behaves as one
        settle();
        write_reg(CFG_IDX_WINDOW_LENGTH, 0);
        send_pair(14'd7, 14'd3, 1'b0, 1'b0, 16'd10);

        // oversized window, then shortened while partly full
        settle();
        write_reg(CFG_IDX_WINDOW_LENGTH, 31);
        send_pair(14'd200, 14'd100, 1'b0, 1'b0, 16'd500);
        send_pair(14'd300, 14'd100, 1'b0, 1'b0, 16'd500);
        send_pair(14'd16383, 14'd16000, 1'b0, 1'b0, 16'd500);
        settle();
        write_reg(CFG_IDX_WINDOW_LENGTH, 2);
        send_pair(14'd1, 14'd2, 1'b0, 1'b0, 16'd999);

        // widest threshold never wraps, zero threshold wraps any nonzero step
        settle();
        write_reg(CFG_IDX_WINDOW_LENGTH, 1);
        write_reg(CFG_IDX_WRAP_THRESH, 16383);
        send_pair(14'd16383, 14'd0, 1'b0, 1'b0, 16'd1);
        settle();
        write_reg(CFG_IDX_WRAP_THRESH, 0);
        send_pair(14'd1, 14'd0, 1'b0, 1'b0, 16'd7);
        send_pair(14'd0, 14'd0, 1'b0, 1'b0, 16'd0);

        // random: three idle phases, four register settings in each
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 66;
                rx_idle_pct = 19;
            end else if (phase == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int seg = 0; seg < 4; seg++) begin
                k = phase * 4 + seg;
                case (k)
                    0: apply_setting(65535, 16383, 16);
                    1: apply_setting(1, 1, 1);
                    2: apply_setting(0, 0, 0);
                    3: apply_setting(2500, 10467, 31);
                    default: begin
                        case ($urandom_range(3))
                            0: max_iv = 2500;
                            1: max_iv = 65535;
                            2: max_iv = $urandom_range(200, 1);
                            default: max_iv = $urandom_range(65535);
                        endcase
                        case ($urandom_range(3))
                            0: wrap = 10467;
                            1: wrap = 8192;
                            2: wrap = 16383;
                            default: wrap = $urandom_range(16383);
                        endcase
                        win = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
                        apply_setting(max_iv, wrap, win);
                    end
                endcase
                repeat (SEG_PAIRS) send_random_pair();
            end
        end

        // drain: every expected speed back, then let the divider go quiet
        settle();

        $display("%0d reading pair requests under %0d register settings, %0d speed results checked",
                 pairs_sent, settings_used, checked);
        $display("covered wraps, rejected pairs, zero-time and clipped speeds, odd window lengths");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
